// File: hdl/lsr_pkg.sv
// Package: constants, types and mode codes for the letterbox rectangle block.
package lsr_pkg;
	localparam int DIM_BITS_DEF = 14;
	localparam logic [1:0] MODE_FILL = 2'd0;
	localparam logic [1:0] MODE_FIT = 2'd1;
	localparam logic [1:0] MODE_MULT = 2'd2;
	localparam logic [1:0] REG_SRC_W = 2'd0;
	localparam logic [1:0] REG_SRC_H = 2'd1;
	localparam logic [1:0] REG_MODE = 2'd2;

	// per-beat control carried along the division chain
	typedef struct packed {
		logic vld;
		logic bypass;    // whole target at origin
		logic integ;     // integer mode requested
		logic hlim;      // aspect: height is the limiting axis
	} ctl_t;
endpackage

// File: hdl/lsr_div_cell.sv
// One restoring-division step cell for three quotients in flight.
module lsr_div_cell #(
	parameter int DB = lsr_pkg::DIM_BITS_DEF,
	parameter int QW = 2 * DB,
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  lsr_pkg::ctl_t ctl_i,
	input  logic [DB-1:0] dw_i, dh_i, sw_i, sh_i,
	input  logic [QW-1:0] na_i, nb_i, nc_i,
	input  logic [DB-1:0] da_i, db_i, dc_i,
	input  logic [DB-1:0] ra_i, rb_i, rc_i,
	input  logic [QW-1:0] qa_i, qb_i, qc_i,
	output lsr_pkg::ctl_t ctl_o,
	output logic [DB-1:0] dw_o, dh_o, sw_o, sh_o,
	output logic [QW-1:0] na_o, nb_o, nc_o,
	output logic [DB-1:0] da_o, db_o, dc_o,
	output logic [DB-1:0] ra_o, rb_o, rc_o,
	output logic [QW-1:0] qa_o, qb_o, qc_o
);
	// r is the partial remainder; step brings in numerator bit BIT and
	// returns {quotient bit, new remainder}
	function automatic logic [DB:0] step(input logic [DB-1:0] r,
			input logic [QW-1:0] n, input logic [DB-1:0] d);
		logic [DB:0] t;
		begin
			t = {r, n[BIT]};
			if (t >= {1'b0, d})
				step = {1'b1, DB'(t - {1'b0, d})};
			else
				step = {1'b0, t[DB-1:0]};
		end
	endfunction
	logic [DB:0] sa, sb, sc;
	assign sa = step(ra_i, na_i, da_i);
	assign sb = step(rb_i, nb_i, db_i);
	assign sc = step(rc_i, nc_i, dc_i);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_o <= '0;
		end else begin
			ctl_o <= ctl_i;
		end
	end
	always_ff @(posedge clk) begin
		dw_o <= dw_i; dh_o <= dh_i; sw_o <= sw_i; sh_o <= sh_i;
		na_o <= na_i; nb_o <= nb_i; nc_o <= nc_i;
		da_o <= da_i; db_o <= db_i; dc_o <= dc_i;
		ra_o <= sa[DB-1:0];
		rb_o <= sb[DB-1:0];
		rc_o <= sc[DB-1:0];
		qa_o <= {qa_i[QW-2:0], sa[DB]};
		qb_o <= {qb_i[QW-2:0], sb[DB]};
		qc_o <= {qc_i[QW-2:0], sc[DB]};
	end
endmodule

// File: hdl/letterbox_scale_rect.sv
// Top level: letterbox rectangle from target size, source size and scale mode.
//
// Use: pulse start with target_width/target_height; busy is always low, so a
// query is taken in every cycle start is high. Registers src_width (index 0),
// src_height (1), scale_mode (2) use cfg_we/cfg_idx/cfg_wdata; the user writes
// them only while no query is in flight; the block does not enforce this.
// Flow: one stage forms products; the next compares aspects and picks the
// numerators; then a row of 2*DIM_BITS identical division cells, one quotient
// bit each, carries three divisions at once (integer factors dw/sw and dh/sh,
// and the rounded aspect quotient); a stage picks the integer factor,
// multiplies and clamps the aspect size; a final stage selects and centers.
// done marks the result beat for one cycle.
// Throughput one query per cycle. Reset clears the valid chain and loads the
// register reset values (640, 480, stretch). The receiver cannot stall.
module letterbox_scale_rect #(
	parameter int DIM_BITS = lsr_pkg::DIM_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [DIM_BITS-1:0] target_width,
	input  logic [DIM_BITS-1:0] target_height,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [DIM_BITS-1:0] cfg_wdata,
	output logic done,
	output logic [DIM_BITS-1:0] rect_x,
	output logic [DIM_BITS-1:0] rect_y,
	output logic [DIM_BITS-1:0] rect_w,
	output logic [DIM_BITS-1:0] rect_h
);
	localparam int DB = DIM_BITS;
	localparam int QW = 2 * DB;
	localparam int NC = QW;

	logic [DB-1:0] src_w_q, src_h_q;
	logic [1:0] mode_q;
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DB'(640);
			src_h_q <= DB'(480);
			mode_q <= lsr_pkg::MODE_FILL;
		end else if (cfg_we) begin
			case (cfg_idx)
				lsr_pkg::REG_SRC_W: src_w_q <= cfg_wdata;
				lsr_pkg::REG_SRC_H: src_h_q <= cfg_wdata;
				lsr_pkg::REG_MODE:  mode_q <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// stage 1: products, bypass and integer-mode flags
	lsr_pkg::ctl_t ctl_s1;
	logic [DB-1:0] dw_s1, dh_s1, sw_s1, sh_s1;
	logic [QW-1:0] p_swdh_s1, p_dwsh_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.vld <= start;
			ctl_s1.bypass <= (src_w_q == '0) || (src_h_q == '0) ||
				(target_width == '0) || (target_height == '0) ||
				(mode_q == lsr_pkg::MODE_FILL);
			ctl_s1.integ <= (mode_q == lsr_pkg::MODE_MULT);
			ctl_s1.hlim <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		dw_s1 <= target_width; dh_s1 <= target_height;
		sw_s1 <= src_w_q; sh_s1 <= src_h_q;
		p_swdh_s1 <= QW'(src_w_q) * QW'(target_height);
		p_dwsh_s1 <= QW'(target_width) * QW'(src_h_q);
	end

	// stage 2: aspect compare, pick aspect numerator/divisor (add half divisor for rounding)
	lsr_pkg::ctl_t ctl_s2;
	logic [DB-1:0] dw_s2, dh_s2, sw_s2, sh_s2;
	logic [QW-1:0] na_s2, nb_s2, nc_s2;
	logic [DB-1:0] da_s2, db_s2, dc_s2;
	lsr_pkg::ctl_t ctl_c [0:NC];
	logic [DB-1:0] dw_c [0:NC], dh_c [0:NC], sw_c [0:NC], sh_c [0:NC];
	logic [QW-1:0] na_c [0:NC], nb_c [0:NC], nc_c [0:NC];
	logic [DB-1:0] da_c [0:NC], db_c [0:NC], dc_c [0:NC];
	logic [DB-1:0] ra_c [0:NC], rb_c [0:NC], rc_c [0:NC];
	logic [QW-1:0] qa_c [0:NC], qb_c [0:NC], qc_c [0:NC];
	logic hl;
	assign hl = !(p_swdh_s1 > p_dwsh_s1);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2.vld <= ctl_s1.vld;
			ctl_s2.bypass <= ctl_s1.bypass;
			ctl_s2.integ <= ctl_s1.integ;
			ctl_s2.hlim <= hl;
		end
	end
	always_ff @(posedge clk) begin
		dw_s2 <= dw_s1; dh_s2 <= dh_s1; sw_s2 <= sw_s1; sh_s2 <= sh_s1;
		na_s2 <= QW'(dw_s1); da_s2 <= sw_s1;
		nb_s2 <= QW'(dh_s1); db_s2 <= sh_s1;
		if (hl) begin
			nc_s2 <= p_swdh_s1 + QW'(sh_s1 >> 1); dc_s2 <= sh_s1;
		end else begin
			nc_s2 <= p_dwsh_s1 + QW'(sw_s1 >> 1); dc_s2 <= sw_s1;
		end
	end
	assign ctl_c[0] = ctl_s2;
	assign dw_c[0] = dw_s2;
	assign dh_c[0] = dh_s2;
	assign sw_c[0] = sw_s2;
	assign sh_c[0] = sh_s2;
	assign na_c[0] = na_s2;
	assign nb_c[0] = nb_s2;
	assign nc_c[0] = nc_s2;
	assign da_c[0] = da_s2;
	assign db_c[0] = db_s2;
	assign dc_c[0] = dc_s2;
	assign ra_c[0] = '0;
	assign rb_c[0] = '0;
	assign rc_c[0] = '0;
	assign qa_c[0] = '0;
	assign qb_c[0] = '0;
	assign qc_c[0] = '0;

	for (genvar i = 0; i < NC; i++) begin : g_cell
		lsr_div_cell #(.DB(DB), .QW(QW), .BIT(NC - 1 - i)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl_i(ctl_c[i]),
			.dw_i(dw_c[i]), .dh_i(dh_c[i]), .sw_i(sw_c[i]), .sh_i(sh_c[i]),
			.na_i(na_c[i]), .nb_i(nb_c[i]), .nc_i(nc_c[i]),
			.da_i(da_c[i]), .db_i(db_c[i]), .dc_i(dc_c[i]),
			.ra_i(ra_c[i]), .rb_i(rb_c[i]), .rc_i(rc_c[i]),
			.qa_i(qa_c[i]), .qb_i(qb_c[i]), .qc_i(qc_c[i]),
			.ctl_o(ctl_c[i+1]),
			.dw_o(dw_c[i+1]), .dh_o(dh_c[i+1]), .sw_o(sw_c[i+1]), .sh_o(sh_c[i+1]),
			.na_o(na_c[i+1]), .nb_o(nb_c[i+1]), .nc_o(nc_c[i+1]),
			.da_o(da_c[i+1]), .db_o(db_c[i+1]), .dc_o(dc_c[i+1]),
			.ra_o(ra_c[i+1]), .rb_o(rb_c[i+1]), .rc_o(rc_c[i+1]),
			.qa_o(qa_c[i+1]), .qb_o(qb_c[i+1]), .qc_o(qc_c[i+1])
		);
	end

	// each cell shifts one quotient bit in, MSB first; after the row the
	// quotient registers hold the full quotients
	logic [QW-1:0] qa, qb, qc;
	assign qa = qa_c[NC];
	assign qb = qb_c[NC];
	assign qc = qc_c[NC];

	// stage 3: integer factor, products, aspect size
	lsr_pkg::ctl_t ctl_s3;
	logic use_int_s3;
	logic [DB-1:0] dw_s3, dh_s3, wi_s3, hi_s3, asp_s3;
	logic [DB-1:0] n;
	assign n = (qb[QW-1:0] < qa[QW-1:0]) ? DB'(qb) : DB'(qa);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_c[NC];
		end
	end
	always_ff @(posedge clk) begin
		use_int_s3 <= ctl_c[NC].integ && (n != '0);
		dw_s3 <= dw_c[NC]; dh_s3 <= dh_c[NC];
		wi_s3 <= DB'(QW'(sw_c[NC]) * QW'(n));
		hi_s3 <= DB'(QW'(sh_c[NC]) * QW'(n));
		asp_s3 <= (qc > QW'(ctl_c[NC].hlim ? dw_c[NC] : dh_c[NC])) ?
			(ctl_c[NC].hlim ? dw_c[NC] : dh_c[NC]) :
			((qc == '0) ? DB'(1) : DB'(qc));
	end

	// stage 4: final size and centering
	logic [DB-1:0] w, h;
	always_comb begin
		if (ctl_s3.bypass) begin
			w = dw_s3; h = dh_s3;
		end else if (use_int_s3) begin
			w = wi_s3; h = hi_s3;
		end else if (ctl_s3.hlim) begin
			w = asp_s3; h = dh_s3;
		end else begin
			w = dw_s3; h = asp_s3;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= ctl_s3.vld;
	end
	always_ff @(posedge clk) begin
		rect_w <= w;
		rect_h <= h;
		rect_x <= DB'((dw_s3 - w) >> 1);
		rect_y <= DB'((dh_s3 - h) >> 1);
	end
endmodule

// File: tb/lsr_checker.sv
// Checker: watches queries and result beats, predicts rectangles, compares in order.
module lsr_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic [13:0] target_width,
	input  logic [13:0] target_height,
	input  logic cfg_we,
	input  logic [1:0] cfg_idx,
	input  logic [13:0] cfg_wdata,
	input  logic done,
	input  logic [13:0] rect_x,
	input  logic [13:0] rect_y,
	input  logic [13:0] rect_w,
	input  logic [13:0] rect_h,
	output int errors,
	output int pending,
	output int rect_count
);
	typedef struct packed {
		logic [13:0] x;
		logic [13:0] y;
		logic [13:0] w;
		logic [13:0] h;
	} rect_t;

	logic [13:0] src_w, src_h;
	logic [1:0] mode;
	rect_t rect_q[$];

	function automatic rect_t fit_rect(input logic [13:0] dw, input logic [13:0] dh);
		longint unsigned sw, sh, w, h, n, m;
		rect_t r;
		bit fin;
		sw = 64'(src_w);
		sh = 64'(src_h);
		w = 64'(dw);
		h = 64'(dh);
		r.x = '0;
		r.y = '0;
		fin = 0;
		if (sw == 0 || sh == 0 || dw == 0 || dh == 0 || mode == lsr_pkg::MODE_FILL) begin
			fin = 1;
		end else if (mode == lsr_pkg::MODE_MULT) begin
			n = dw / sw;
			m = dh / sh;
			if (m < n) n = m;
			if (n >= 1) begin
				w = sw * n;
				h = sh * n;
				fin = 1;
			end
		end
		if (!fin) begin
			// tie goes to height-limited
			if (sw * dh > dw * sh) begin
				w = dw;
				h = (dw * sh + sw / 2) / sw;
			end else begin
				h = dh;
				w = (dh * sw + sh / 2) / sh;
			end
			if (w < 1) w = 1;
			if (h < 1) h = 1;
			if (w > dw) w = dw;
			if (h > dh) h = dh;
		end
		if (!(sw == 0 || sh == 0 || dw == 0 || dh == 0 || mode == lsr_pkg::MODE_FILL)) begin
			r.x = 14'((dw - w) / 2);
			r.y = 14'((dh - h) / 2);
		end
		r.w = 14'(w);
		r.h = 14'(h);
		return r;
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rect_t e;
		if (!arst_n) begin
			src_w <= 14'd640;
			src_h <= 14'd480;
			mode <= lsr_pkg::MODE_FILL;
			errors = 0;
			rect_count = 0;
			rect_q.delete();
		end else begin
			if (done) begin
				rect_count++;
				if (rect_q.size() == 0) begin
					report("unexpected beat", 0, 0);
				end else begin
					e = rect_q.pop_front();
					if (rect_x !== e.x) report("rect_x", int'(rect_x), int'(e.x));
					if (rect_y !== e.y) report("rect_y", int'(rect_y), int'(e.y));
					if (rect_w !== e.w) report("rect_w", int'(rect_w), int'(e.w));
					if (rect_h !== e.h) report("rect_h", int'(rect_h), int'(e.h));
				end
			end
			if (start && !busy) rect_q.push_back(fit_rect(target_width, target_height));
			if (cfg_we) begin
				case (cfg_idx)
					lsr_pkg::REG_SRC_W: src_w <= cfg_wdata;
					lsr_pkg::REG_SRC_H: src_h <= cfg_wdata;
					lsr_pkg::REG_MODE: mode <= cfg_wdata[1:0];
					default: ;
				endcase
			end
		end
		pending = rect_q.size();
	end
endmodule

// File: tb/tb_letterbox_scale_rect.sv
// Testbench top: drives size queries and register writes, gives the verdict.
module tb_letterbox_scale_rect;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic clk, arst_n, start, busy, cfg_we, done;
	logic [13:0] target_width, target_height, cfg_wdata;
	logic [1:0] cfg_idx;
	logic [13:0] rect_x, rect_y, rect_w, rect_h;
	int errors, pending, rect_count;
	int gap_pct;
	int sent;

	letterbox_scale_rect dut (.*);

	lsr_checker chk (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// hard stop; the block has no back-pressure so this is very generous
	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	// one query beat, preceded by random idle cycles per gap_pct
	task automatic query(input logic [13:0] dw, input logic [13:0] dh);
		while ($urandom_range(99) < gap_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		target_width <= dw;
		target_height <= dh;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// drain: all results in, then the pipeline depth plus margin
	task automatic settle();
		start <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// write beat, then cfg_we deasserted before returning
	task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		@(posedge clk);
	endtask

	// small sources mostly, so integer mode often finds factors of one or more
	function automatic logic [13:0] rnd_dim();
		case ($urandom_range(9))
			0: return 14'($urandom_range(3));
			1: return 14'h3fff - 14'($urandom_range(3));
			2, 3, 4: return 14'($urandom_range(1, 64));
			5, 6: return 14'($urandom_range(1, 2048));
			default: return 14'($urandom);
		endcase
	endfunction

	task automatic directed();
		query(0, 0);
		query(14'h3fff, 14'h3fff);
		query(0, 100);
		query(100, 0);
		query(1, 1);
		query(1920, 1080);
		query(14'h3fff, 1);
		query(1, 14'h3fff);
		query(1280, 960);   // exact aspect tie
		query(639, 479);    // below source: integer falls back to aspect
		query(14'h2aaa, 14'h1555);
	endtask

	initial begin
		arst_n = 0;
		start = 0;
		cfg_we = 0;
		cfg_idx = lsr_pkg::REG_SRC_W;
		cfg_wdata = 0;
		target_width = 0;
		target_height = 0;
		gap_pct = 0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed pass over all modes, reset source first
		for (int md = 0; md < 4; md++) begin
			write_reg(lsr_pkg::REG_MODE, 14'(md));
			@(posedge clk);
			directed();
			settle();
		end
		write_reg(lsr_pkg::REG_SRC_W, 0);
		write_reg(lsr_pkg::REG_SRC_H, 14'h3fff);
		write_reg(lsr_pkg::REG_MODE, 14'(lsr_pkg::MODE_FIT));
		directed();
		settle();
		write_reg(lsr_pkg::REG_SRC_W, 14'h3fff);
		write_reg(lsr_pkg::REG_SRC_H, 1);
		write_reg(REG_UNUSED, 14'h1234);   // unused index, ignored
		directed();
		settle();

		// random phases: each picks a fresh source and mode
		for (int ph = 0; ph < 34; ph++) begin
			gap_pct = (ph < 11) ? 21 : (ph < 22) ? 45 : 0;
			write_reg(lsr_pkg::REG_SRC_W, rnd_dim());
			write_reg(lsr_pkg::REG_SRC_H, rnd_dim());
			write_reg(lsr_pkg::REG_MODE, 14'($urandom));
			@(posedge clk);
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(3) == 0) query(14'($urandom), 14'($urandom));
				else query(rnd_dim(), rnd_dim());
				sent++;
			end
			settle();
		end

		$display("covered: all scale modes, zero and full-scale sizes, %0d random queries",
			sent);
		$display("result beats checked: %0d", rect_count);
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// File: letterbox_scale_rect.f
hdl/lsr_pkg.sv
hdl/lsr_div_cell.sv
hdl/letterbox_scale_rect.sv
tb/lsr_checker.sv
tb/tb_letterbox_scale_rect.sv
